// ----- hdl/dependency_counting_job_scheduler_core_assert.svh -----
// Assertion macros shared by the job scheduler modules.
`ifndef DEPENDENCY_COUNTING_JOB_SCHEDULER_CORE_ASSERT_SVH
`define DEPENDENCY_COUNTING_JOB_SCHEDULER_CORE_ASSERT_SVH
`define DCJS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DCJS_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);
`endif

// ----- hdl/dcjs_pkg.sv -----
// Package of types and constants for the job scheduler.
package dcjs_pkg;
	localparam int unsigned QueueDepth = 512;
	localparam int unsigned AddrW = $clog2(QueueDepth);
	localparam int unsigned FillW = $clog2(QueueDepth + 1);
	localparam int unsigned PayloadW = 32;
	localparam logic [15:0] NoParent = 16'hFFFF;
	localparam int unsigned ReadyW = PayloadW + 16;
	localparam int unsigned WaitW = PayloadW + 32;

	localparam logic [1:0] ActFree = 2'd0;
	localparam logic [1:0] ActParent = 2'd1;
	localparam logic [1:0] ActFetch = 2'd2;
	localparam logic [1:0] ActFinish = 2'd3;

	localparam logic [2:0] StOk = 3'd0;
	localparam logic [2:0] StReadyFull = 3'd1;
	localparam logic [2:0] StWaitFull = 3'd2;
	localparam logic [2:0] StReadyEmpty = 3'd3;
	localparam logic [2:0] StNotFound = 3'd4;

	typedef struct packed {
		logic push_free;
		logic push_parent;
		logic fetch_done;
		logic scan_start;
		logic scan_rd;
		logic dec_wr;
		logic rel_rd_head;
		logic rel_commit;
		logic set_status;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic ready_full;
		logic ready_empty;
		logic wait_full;
		logic scan_end;
		logic scan_hit;
		logic count_one;
	} sts_t;
endpackage

// ----- hdl/dcjs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module dcjs_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/dcjs_datapath.sv -----
// Datapath of the job scheduler: ring, table, pointers and result registers.
`include "dependency_counting_job_scheduler_core_assert.svh"
module dcjs_datapath (
	input logic clk,
	input logic arst_n,
	input logic in_take,
	input logic [31:0] job_payload,
	input logic [15:0] parent_id,
	input logic [15:0] child_count,
	input dcjs_pkg::cmd_t cmd,
	output dcjs_pkg::sts_t sts,
	output logic [2:0] status,
	output logic [15:0] assigned_id,
	output logic [31:0] job_out,
	output logic [15:0] job_parent_out,
	output logic released,
	output logic idle
);
	localparam int unsigned AW = dcjs_pkg::AddrW;
	localparam int unsigned FW = dcjs_pkg::FillW;

	logic [AW-1:0] r_head_q, r_tail_q, w_head_q, w_tail_q, pos_q;
	logic [FW-1:0] r_fill_q, w_fill_q, n_q;
	logic [15:0] next_id_q, pid_q, cnt_q;
	logic [31:0] pay_q;
	logic [dcjs_pkg::WaitW-1:0] hit_q;

	logic r_we, w_we;
	logic [AW-1:0] r_waddr, w_waddr, w_raddr;
	logic [dcjs_pkg::ReadyW-1:0] r_wdata, r_rdata;
	logic [dcjs_pkg::WaitW-1:0] w_wdata, w_rdata;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (32'(p) + 32'd1 >= dcjs_pkg::QueueDepth) ? '0 : p + AW'(1);
	endfunction

	dcjs_ram #(.Width(dcjs_pkg::ReadyW), .Depth(dcjs_pkg::QueueDepth)) u_ready (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_head_q), .rdata(r_rdata)
	);
	dcjs_ram #(.Width(dcjs_pkg::WaitW), .Depth(dcjs_pkg::QueueDepth)) u_wait (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	always_comb begin
		r_we = cmd.push_free || cmd.rel_commit;
		r_waddr = r_tail_q;
		r_wdata = cmd.rel_commit ? {hit_q[63:32], dcjs_pkg::NoParent} : {pay_q, pid_q};
		w_we = cmd.push_parent || cmd.dec_wr || cmd.rel_commit;
		w_waddr = cmd.push_parent ? w_tail_q : pos_q;
		if (cmd.push_parent) begin
			w_wdata = {pay_q, next_id_q, cnt_q};
		end else if (cmd.dec_wr) begin
			w_wdata = {hit_q[63:16], hit_q[15:0] - 16'd1};
		end else begin
			w_wdata = w_rdata;
		end
		w_raddr = cmd.rel_rd_head ? w_head_q : pos_q;
		sts.ready_full = r_fill_q == FW'(dcjs_pkg::QueueDepth);
		sts.ready_empty = r_fill_q == '0;
		sts.wait_full = w_fill_q == FW'(dcjs_pkg::QueueDepth);
		sts.scan_end = n_q == w_fill_q;
		sts.scan_hit = w_rdata[31:16] == pid_q;
		sts.count_one = hit_q[15:0] == 16'd1;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pay_q <= job_payload;
			pid_q <= parent_id;
			cnt_q <= child_count;
		end
		if (cmd.scan_rd && sts.scan_hit) begin
			hit_q <= w_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_head_q <= '0;
			r_tail_q <= '0;
			r_fill_q <= '0;
			w_head_q <= '0;
			w_tail_q <= '0;
			w_fill_q <= '0;
			next_id_q <= '0;
			pos_q <= '0;
			n_q <= '0;
			status <= '0;
			assigned_id <= '0;
			job_out <= '0;
			job_parent_out <= '0;
			released <= 1'b0;
			idle <= 1'b1;
		end else begin
			if (in_take) begin
				assigned_id <= '0;
				job_out <= '0;
				job_parent_out <= '0;
				released <= 1'b0;
			end
			if (cmd.set_status) begin
				status <= cmd.status;
			end
			if (cmd.push_free) begin
				r_tail_q <= wrap_inc(r_tail_q);
				r_fill_q <= r_fill_q + FW'(1);
			end
			if (cmd.push_parent) begin
				w_tail_q <= wrap_inc(w_tail_q);
				w_fill_q <= w_fill_q + FW'(1);
				assigned_id <= next_id_q;
				next_id_q <= (next_id_q + 16'd1 >= dcjs_pkg::NoParent) ? '0
					: next_id_q + 16'd1;
			end
			if (cmd.fetch_done) begin
				job_out <= r_rdata[47:16];
				job_parent_out <= r_rdata[15:0];
				r_head_q <= wrap_inc(r_head_q);
				r_fill_q <= r_fill_q - FW'(1);
			end
			if (cmd.scan_start) begin
				pos_q <= w_head_q;
				n_q <= '0;
			end else if (cmd.scan_rd && !sts.scan_hit) begin
				pos_q <= wrap_inc(pos_q);
				n_q <= n_q + FW'(1);
			end
			if (cmd.rel_commit) begin
				r_tail_q <= wrap_inc(r_tail_q);
				r_fill_q <= r_fill_q + FW'(1);
				w_head_q <= wrap_inc(w_head_q);
				w_fill_q <= w_fill_q - FW'(1);
				released <= 1'b1;
			end
			idle <= (r_fill_q == '0) && (w_fill_q == '0);
		end
	end

	`DCJS_ASSERT_IMPL(a_rfill, clk, arst_n, r_fill_q <= FW'(dcjs_pkg::QueueDepth),
		"ready fill over depth")
	`DCJS_ASSERT_IMPL(a_wfill, clk, arst_n, w_fill_q <= FW'(dcjs_pkg::QueueDepth),
		"table fill over depth")
	`DCJS_ASSERT_IMPL(a_scan, clk, arst_n, !(cmd.scan_rd && sts.scan_end),
		"scan past fill")
endmodule

// ----- hdl/dcjs_ctrl.sv -----
// Controller state machine of the job scheduler.
`include "dependency_counting_job_scheduler_core_assert.svh"
module dcjs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [15:0] parent_id,
	output logic out_valid,
	input logic out_stall,
	input dcjs_pkg::sts_t sts,
	output dcjs_pkg::cmd_t cmd,
	output logic in_take
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_EXEC = 8'b0000_0010,
		S_FETCH = 8'b0000_0100,
		S_SCAN = 8'b0000_1000,
		S_CHECK = 8'b0001_0000,
		S_RDHEAD = 8'b0010_0000,
		S_MOVE = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] act_q;
	logic nop_q;
	logic first_q;
	logic ov_q;

	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign in_take = in_valid && !in_stall;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				cmd.set_status = 1'b1;
				cmd.status = dcjs_pkg::StOk;
				unique case (act_q)
					dcjs_pkg::ActFree: begin
						if (sts.ready_full) begin
							cmd.status = dcjs_pkg::StReadyFull;
						end else begin
							cmd.push_free = 1'b1;
						end
					end
					dcjs_pkg::ActParent: begin
						if (sts.wait_full) begin
							cmd.status = dcjs_pkg::StWaitFull;
						end else begin
							cmd.push_parent = 1'b1;
						end
					end
					dcjs_pkg::ActFetch: begin
						if (sts.ready_empty) begin
							cmd.status = dcjs_pkg::StReadyEmpty;
						end else begin
							state_d = S_FETCH;
							cmd.set_status = 1'b0;
						end
					end
					default: begin
						if (!nop_q) begin
							cmd.set_status = 1'b0;
							cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end
					end
				endcase
			end
			S_FETCH: begin
				cmd.fetch_done = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status = dcjs_pkg::StOk;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					cmd.set_status = 1'b1;
					cmd.status = dcjs_pkg::StNotFound;
					state_d = S_DONE;
				end else if (!first_q) begin
					cmd.scan_rd = 1'b1;
					if (sts.scan_hit) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.set_status = 1'b1;
				cmd.status = dcjs_pkg::StOk;
				if (!sts.count_one) begin
					cmd.dec_wr = 1'b1;
					state_d = S_DONE;
				end else if (sts.ready_full) begin
					cmd.status = dcjs_pkg::StReadyFull;
					state_d = S_DONE;
				end else begin
					cmd.set_status = 1'b0;
					cmd.rel_rd_head = 1'b1;
					state_d = S_RDHEAD;
				end
			end
			S_RDHEAD: begin
				cmd.rel_rd_head = 1'b1;
				state_d = S_MOVE;
			end
			S_MOVE: begin
				cmd.rel_commit = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status = dcjs_pkg::StOk;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= dcjs_pkg::ActFree;
			nop_q <= 1'b0;
			first_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				act_q <= action;
				nop_q <= parent_id == dcjs_pkg::NoParent;
			end
			first_q <= cmd.scan_start || (cmd.scan_rd && !sts.scan_hit);
			if (state_q == S_DONE) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	`DCJS_ASSERT_IMPL(a_onehot, clk, arst_n, $onehot(state_q), "state not one-hot")
	`DCJS_ASSERT_NEXT(a_done, clk, arst_n, state_q == S_DONE, ov_q, "result lost")
	`DCJS_ASSERT_IMPL(a_push, clk, arst_n, !(cmd.push_free && cmd.rel_commit),
		"two ring pushes")
endmodule

// ----- hdl/dependency_counting_job_scheduler_core.sv -----
// Top level of the dependency-counting job scheduler.
// Usage:
//   Input channel in_valid/in_stall carries one word: action, job_payload,
//   parent_id and child_count. Output channel out_valid/out_stall returns one
//   word per input: status, assigned_id, job_out, job_parent_out, released
//   and idle.
//   One word is handled at a time. A submit runs the states EXEC and DONE, a
//   fetch EXEC, FETCH and DONE. A finish scans the parent table from its front,
//   entry by entry, until the parent is found or all entries (up to 512) have
//   been read; a found parent is decremented, or released at a count of one.
//   Full or empty stores are reported in status; nothing blocks on them.
//   A finished result stays on the output while out_stall is high; the next
//   input word is not taken until the result has been taken or the
//   output register is free.
//   Reset (arst_n low) empties the ring and the table and restarts parent
//   ids from zero; no clearing pass is needed.
module dependency_counting_job_scheduler_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [31:0] job_payload,
	input logic [15:0] parent_id,
	input logic [15:0] child_count,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [15:0] assigned_id,
	output logic [31:0] job_out,
	output logic [15:0] job_parent_out,
	output logic released,
	output logic idle
);
	dcjs_pkg::cmd_t cmd;
	dcjs_pkg::sts_t sts;
	logic in_take;

	dcjs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.action(action), .parent_id(parent_id), .out_valid(out_valid),
		.out_stall(out_stall), .sts(sts), .cmd(cmd), .in_take(in_take)
	);

	dcjs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_take(in_take),
		.job_payload(job_payload), .parent_id(parent_id),
		.child_count(child_count), .cmd(cmd), .sts(sts), .status(status),
		.assigned_id(assigned_id), .job_out(job_out),
		.job_parent_out(job_parent_out), .released(released), .idle(idle)
	);
endmodule
